/* hw/rtl/crs_pkg.sv */
// Shared types, constants and codes for the cold room supervisor.
package crs_pkg;

  localparam int unsigned DoorHoldMs   = 3000;
  localparam int unsigned MinDwellMs   = 4000;
  localparam int unsigned PeriodCrit   = 250;
  localparam int unsigned PeriodDoor   = 700;
  localparam int unsigned PeriodFault  = 500;
  localparam int unsigned FifoDepthDef = 4;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgAddrW = 5;

  typedef enum logic [2:0] {
    ST_FAULT    = 3'd0,
    ST_CRITICAL = 3'd1,
    ST_DOOR     = 3'd2,
    ST_COOLING  = 3'd3,
    ST_STEADY   = 3'd4
  } crs_state_e;

  typedef enum logic [1:0] {
    TONE_OFF  = 2'd0,
    TONE_1000 = 2'd1,
    TONE_1500 = 2'd2,
    TONE_2000 = 2'd3
  } crs_tone_e;

  typedef enum logic [2:0] {
    REG_CRIT_ON    = 3'd0,
    REG_CRIT_OFF   = 3'd1,
    REG_COOL_ON    = 3'd2,
    REG_COOL_OFF   = 3'd3,
    REG_HUM_ON     = 3'd4,
    REG_HUM_OFF    = 3'd5,
    REG_LIGHT_OPEN = 3'd6,
    REG_LIGHT_SHUT = 3'd7
  } crs_reg_e;

  typedef enum logic {
    PH_LOAD = 1'b0,
    PH_EXEC = 1'b1
  } crs_phase_e;

  typedef struct packed {
    logic signed [10:0] crit_on;
    logic signed [10:0] crit_off;
    logic signed [10:0] cool_on;
    logic signed [10:0] cool_off;
    logic [9:0]         hum_on;
    logic [9:0]         hum_off;
    logic [11:0]        light_open;
    logic [11:0]        light_shut;
  } crs_cfg_t;

  // Classified request as it waits in the queue
  typedef struct packed {
    logic        is_tick;
    logic [31:0] now;
    logic        valid;
    logic        ge_crit_on;
    logic        lt_crit_off;
    logic        ge_cool_on;
    logic        le_cool_off;
    logic        ge_hum_on;
    logic        lt_hum_off;
    logic        lit;
    logic        ge_shut;
  } crs_item_t;

  // Time checks formed in the first back-end cycle
  typedef struct packed {
    logic hold_ok;
    logic dwell_ok;
    logic ge_crit;
    logic ge_door;
    logic ge_fault;
  } crs_timing_t;

  typedef struct packed {
    logic       changed;
    logic       door_open;
    logic [1:0] tone;
    logic       buzzer;
    logic       blue;
    logic       green;
    logic       red;
    logic       relay;
    logic [2:0] node_state;
  } crs_result_t;

endpackage

/* hw/rtl/crs_front.sv */
// Front end: unpacks a request and classifies it against the thresholds.
module crs_front import crs_pkg::*; (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,  // now_ms, reading_valid, temperature, humidity,
                                            // light_level, zero fill
  input  logic               s_axis_tuser,  // req_type
  input  crs_cfg_t           cfg_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output crs_item_t          q_item_o
);

  logic signed [10:0] temp;
  logic [9:0]         hum;
  logic [11:0]        light;

  assign temp  = $signed(s_axis_tdata[43:33]);
  assign hum   = s_axis_tdata[53:44];
  assign light = s_axis_tdata[65:54];

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_item_o.is_tick     = s_axis_tuser;
    q_item_o.now         = s_axis_tdata[31:0];
    q_item_o.valid       = s_axis_tdata[32];
    q_item_o.ge_crit_on  = temp >= cfg_i.crit_on;
    q_item_o.lt_crit_off = temp < cfg_i.crit_off;
    q_item_o.ge_cool_on  = temp >= cfg_i.cool_on;
    q_item_o.le_cool_off = temp <= cfg_i.cool_off;
    q_item_o.ge_hum_on   = hum >= cfg_i.hum_on;
    q_item_o.lt_hum_off  = hum < cfg_i.hum_off;
    q_item_o.lit         = light <= cfg_i.light_open;
    q_item_o.ge_shut     = light >= cfg_i.light_shut;
  end

endmodule

/* hw/rtl/crs_fifo.sv */
// Short request queue between the front end and the back end.
module crs_fifo import crs_pkg::*; #(
  parameter int unsigned DEPTH = FifoDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  crs_item_t item_i,
  input  logic      pop_i,
  output crs_item_t item_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  crs_item_t     mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = count_q == FullCnt;
  assign empty_o = count_q == '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

/* hw/rtl/crs_back.sv */
// Back end: door, latches, state decision, blink and output register.
module crs_back import crs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  crs_item_t           q_item_i,
  output logic                q_pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // node_state, relay_on, led_red, led_green,
                                             // led_blue, buzzer_on, tone_select, door_open,
                                             // state_changed, zero fill
);

  crs_phase_e  ph_q, ph_d;
  crs_item_t   it_q;
  crs_timing_t tm_q, tm_d;

  crs_state_e  cur_q, cur_d;
  logic        door_q, door_d;
  logic        run_q, run_d;
  logic [31:0] lit_start_q, lit_start_d;
  logic        crit_q, crit_d;
  logic        hum_q, hum_d;
  logic        cool_q, cool_d;
  logic [31:0] entry_q, entry_d;
  logic [31:0] blink_start_q, blink_start_d;
  logic        blink_q, blink_d;

  logic        out_valid_q, out_valid_d;
  crs_result_t out_q, out_d;

  logic        commit;
  logic        out_free;
  logic [31:0] lit_diff, dwell_diff, blink_diff;

  crs_state_e  next_st;
  logic        crit_a, hum_a, cool_a, risk, may, changed, tick_due;
  crs_tone_e   tone;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - $bits(crs_result_t))'(0), out_q};

  // Time differences against the state as it stands before this request
  assign lit_diff   = q_item_i.now - lit_start_q;
  assign dwell_diff = q_item_i.now - entry_q;
  assign blink_diff = q_item_i.now - blink_start_q;

  always_comb begin
    tm_d.hold_ok  = lit_diff >= 32'(DoorHoldMs);
    tm_d.dwell_ok = dwell_diff >= 32'(MinDwellMs);
    tm_d.ge_crit  = blink_diff >= 32'(PeriodCrit);
    tm_d.ge_door  = blink_diff >= 32'(PeriodDoor);
    tm_d.ge_fault = blink_diff >= 32'(PeriodFault);
  end

  always_comb begin
    ph_d    = ph_q;
    q_pop_o = 1'b0;
    commit  = 1'b0;
    case (ph_q)
      PH_LOAD: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          ph_d    = PH_EXEC;
        end
      end
      PH_EXEC: begin
        if (out_free) begin
          commit = 1'b1;
          ph_d   = PH_LOAD;
        end
      end
      default: ph_d = PH_LOAD;
    endcase
  end

  always_comb begin
    door_d        = door_q;
    run_d         = run_q;
    lit_start_d   = lit_start_q;
    crit_d        = crit_q;
    hum_d         = hum_q;
    cool_d        = cool_q;
    cur_d         = cur_q;
    entry_d       = entry_q;
    blink_start_d = blink_start_q;
    blink_d       = blink_q;
    next_st       = cur_q;
    crit_a        = 1'b0;
    hum_a         = 1'b0;
    cool_a        = 1'b0;
    risk          = 1'b0;
    may           = 1'b0;
    changed       = 1'b0;
    tick_due      = 1'b0;
    tone          = TONE_OFF;

    if (!it_q.is_tick) begin
      // Door: sustained light opens, dark enough closes
      if (!door_q && it_q.lit) begin
        if (!run_q) begin
          run_d       = 1'b1;
          lit_start_d = it_q.now;
        end else if (tm_q.hold_ok) begin
          door_d = 1'b1;
        end
      end else if (door_q && it_q.ge_shut) begin
        door_d = 1'b0;
        run_d  = 1'b0;
      end else if (!door_q && !it_q.lit) begin
        run_d = 1'b0;
      end

      if (!it_q.valid) begin
        next_st = ST_FAULT;
      end else begin
        crit_a = crit_q || it_q.ge_crit_on;
        crit_d = crit_a && !it_q.lt_crit_off;
        hum_a  = hum_q || it_q.ge_hum_on;
        hum_d  = hum_a && !it_q.lt_hum_off;
        risk   = it_q.ge_cool_on;
        if (crit_d || (risk && door_d) || (risk && hum_d)) begin
          next_st = ST_CRITICAL;
        end else if (door_d) begin
          next_st = ST_DOOR;
        end else begin
          cool_a  = cool_q || it_q.ge_cool_on;
          cool_d  = cool_a && !it_q.le_cool_off;
          next_st = cool_d ? ST_COOLING : ST_STEADY;
        end
      end

      may = (next_st == ST_CRITICAL) || (next_st == ST_FAULT) || tm_q.dwell_ok;
      if ((next_st != cur_q) && may) begin
        cur_d   = next_st;
        entry_d = it_q.now;
        changed = 1'b1;
      end
    end

    // Blink advances on every request, from the updated state
    case (cur_d)
      ST_CRITICAL: tick_due = tm_q.ge_crit;
      ST_DOOR:     tick_due = tm_q.ge_door;
      ST_FAULT:    tick_due = tm_q.ge_fault;
      default:     tick_due = 1'b0;
    endcase
    if (cur_d == ST_COOLING || cur_d == ST_STEADY) begin
      blink_d = 1'b0;
    end else if (tick_due) begin
      blink_start_d = it_q.now;
      blink_d       = !blink_q;
    end

    out_d            = out_q;
    out_d.node_state = cur_d;
    out_d.relay      = 1'b0;
    out_d.red        = 1'b0;
    out_d.green      = 1'b0;
    out_d.blue       = 1'b0;
    case (cur_d)
      ST_FAULT: begin
        out_d.red  = blink_d;
        out_d.blue = blink_d;
        tone       = blink_d ? TONE_1000 : TONE_OFF;
      end
      ST_CRITICAL: begin
        out_d.relay = 1'b1;
        out_d.red   = blink_d;
        tone        = blink_d ? TONE_2000 : TONE_OFF;
      end
      ST_DOOR: begin
        out_d.red   = 1'b1;
        out_d.green = 1'b1;
        tone        = blink_d ? TONE_1500 : TONE_OFF;
      end
      ST_COOLING: begin
        out_d.relay = 1'b1;
        out_d.blue  = 1'b1;
      end
      default: out_d.green = 1'b1;
    endcase
    out_d.tone      = tone;
    out_d.buzzer    = tone != TONE_OFF;
    out_d.door_open = door_d;
    out_d.changed   = changed;

    out_valid_d = (out_valid_q && !m_axis_tready) || commit;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      it_q <= q_item_i;
      tm_q <= tm_d;
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q          <= PH_LOAD;
      out_valid_q   <= 1'b0;
      cur_q         <= ST_STEADY;
      door_q        <= 1'b0;
      run_q         <= 1'b0;
      lit_start_q   <= '0;
      crit_q        <= 1'b0;
      hum_q         <= 1'b0;
      cool_q        <= 1'b0;
      entry_q       <= '0;
      blink_start_q <= '0;
      blink_q       <= 1'b0;
    end else begin
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        cur_q         <= cur_d;
        door_q        <= door_d;
        run_q         <= run_d;
        lit_start_q   <= lit_start_d;
        crit_q        <= crit_d;
        hum_q         <= hum_d;
        cool_q        <= cool_d;
        entry_q       <= entry_d;
        blink_start_q <= blink_start_d;
        blink_q       <= blink_d;
      end
    end
  end

  // A stalled result must not let the supervisor state move on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_EXEC && !out_free) |=> $stable(cur_q) && $stable(door_q))
    else $error("state moved while result was stalled");

  // The door can only open once the lit timer has been running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(door_q) |-> $past(run_q))
    else $error("door opened without a running lit timer");

  // Blink phase stays low outside the alarm states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_q |-> (cur_q == ST_FAULT || cur_q == ST_CRITICAL || cur_q == ST_DOOR))
    else $error("blink phase set in a steady state");

  // Queue is read only when the back end is ready to take a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (ph_q == PH_LOAD && !q_empty_i))
    else $error("queue popped outside the load phase");

endmodule

/* hw/rtl/cold_room_supervisor.sv */
// The back end takes one request at a time: its load phase pops it and registers the time
//   differences, and its execute phase applies the door, latch, state and blink updates
//   and loads the output register, waiting there while the output is stalled.
// The front end accepts a request in any cycle in which the queue has room.
// Reset (rst_ni low, asynchronous): state normal, door closed, latches and timers cleared,
//   queue and output register empty, thresholds back to their defaults.
module cold_room_supervisor import crs_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FifoDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // now_ms, reading_valid, temperature, humidity,
                                              // light_level, zero fill
  input  logic                s_axis_tuser,   // req_type
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // node_state, relay_on, led_red, led_green,
                                              // led_blue, buzzer_on, tone_select, door_open,
                                              // state_changed, zero fill
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  crs_cfg_t  cfg_q;
  crs_item_t push_item, pop_item;
  logic      push, pop, q_full, q_empty;
  logic      cfg_wr;
  crs_reg_e  reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = crs_reg_e'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crit_on    <= 11'sd80;
      cfg_q.crit_off   <= 11'sd70;
      cfg_q.cool_on    <= 11'sd60;
      cfg_q.cool_off   <= 11'sd40;
      cfg_q.hum_on     <= 10'd750;
      cfg_q.hum_off    <= 10'd700;
      cfg_q.light_open <= 12'd1500;
      cfg_q.light_shut <= 12'd2500;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_CRIT_ON:    cfg_q.crit_on    <= $signed(pwdata[10:0]);
        REG_CRIT_OFF:   cfg_q.crit_off   <= $signed(pwdata[10:0]);
        REG_COOL_ON:    cfg_q.cool_on    <= $signed(pwdata[10:0]);
        REG_COOL_OFF:   cfg_q.cool_off   <= $signed(pwdata[10:0]);
        REG_HUM_ON:     cfg_q.hum_on     <= pwdata[9:0];
        REG_HUM_OFF:    cfg_q.hum_off    <= pwdata[9:0];
        REG_LIGHT_OPEN: cfg_q.light_open <= pwdata[11:0];
        REG_LIGHT_SHUT: cfg_q.light_shut <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Signed thresholds read back sign extended
  always_comb begin
    case (reg_sel)
      REG_CRIT_ON:    prdata = 32'(cfg_q.crit_on);
      REG_CRIT_OFF:   prdata = 32'(cfg_q.crit_off);
      REG_COOL_ON:    prdata = 32'(cfg_q.cool_on);
      REG_COOL_OFF:   prdata = 32'(cfg_q.cool_off);
      REG_HUM_ON:     prdata = {22'd0, cfg_q.hum_on};
      REG_HUM_OFF:    prdata = {22'd0, cfg_q.hum_off};
      REG_LIGHT_OPEN: prdata = {20'd0, cfg_q.light_open};
      REG_LIGHT_SHUT: prdata = {20'd0, cfg_q.light_shut};
      default:        prdata = '0;
    endcase
  end

  crs_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_i         (cfg_q),
    .q_full_i      (q_full),
    .q_push_o      (push),
    .q_item_o      (push_item)
  );

  crs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  crs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_item_i      (pop_item),
    .q_pop_o       (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* tb/sv/testbench.sv */
// Stream testbench for the cold room supervisor: directed and random requests checked per field.
`timescale 1ns / 100ps

module testbench import crs_pkg::*;;

  localparam int QuietLimit = 2000;
  localparam int SettleCycles = 10;

  typedef struct packed {
    logic               is_tick;
    logic [31:0]        now;
    logic               valid;
    logic signed [10:0] temp;
    logic [9:0]         hum;
    logic [11:0]        light;
  } room_req_t;

  typedef struct packed {
    logic [2:0] state;
    logic       relay;
    logic       red;
    logic       green;
    logic       blue;
    logic       buzzer;
    logic [1:0] tone;
    logic       door;
    logic       changed;
  } room_out_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  cold_room_supervisor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Thresholds as the block should hold them
  int          cfg_crit_on = 80;
  int          cfg_crit_off = 70;
  int          cfg_cool_on = 60;
  int          cfg_cool_off = 40;
  logic [9:0]  cfg_hum_on = 10'd750;
  logic [9:0]  cfg_hum_off = 10'd700;
  logic [11:0] cfg_light_open = 12'd1500;
  logic [11:0] cfg_light_shut = 12'd2500;

  // Room state as the block should hold it
  crs_state_e  room_state = ST_STEADY;
  logic        door_flag = 1'b0;
  logic        lit_running = 1'b0;
  logic [31:0] lit_start = '0;
  logic        crit_latch = 1'b0;
  logic        hum_latch = 1'b0;
  logic        cool_latch = 1'b0;
  logic [31:0] entry_ms = '0;
  logic [31:0] blink_start = '0;
  logic        blink_phase = 1'b0;

  room_req_t   sample_q[$];
  room_out_t   outcome_q[$];
  int          mismatch_cnt = 0;
  int          taken_cnt = 0;
  int          quiet_cycles = 0;

  logic [31:0] stamp_ms = '0;
  int          light_mode = 2;

  function automatic int sext11(input logic [10:0] v);
    return {{21{v[10]}}, v};
  endfunction

  function automatic logic [InDataW-1:0] pack_req(input room_req_t r);
    logic [InDataW-1:0] d;
    d = '0;
    d[31:0]  = r.now;
    d[32]    = r.valid;
    d[43:33] = r.temp;
    d[53:44] = r.hum;
    d[65:54] = r.light;
    return d;
  endfunction

  // Advance the room state by one request and return the expected outputs
  function automatic room_out_t supervise(input room_req_t r);
    room_out_t   o;
    crs_state_e  nxt;
    crs_tone_e   tone;
    logic [31:0] dt;
    logic        risk;
    logic        urgent;
    logic        changed;
    int          t;
    int unsigned period;
    o = '0;
    changed = 1'b0;
    tone = TONE_OFF;
    if (!r.is_tick) begin
      if (!door_flag && r.light <= cfg_light_open) begin
        if (!lit_running) begin
          lit_running = 1'b1;
          lit_start = r.now;
        end
        dt = r.now - lit_start;
        if (dt >= DoorHoldMs) door_flag = 1'b1;
      end else if (door_flag && r.light >= cfg_light_shut) begin
        door_flag = 1'b0;
        lit_running = 1'b0;
      end else if (!door_flag && r.light > cfg_light_open) begin
        lit_running = 1'b0;
      end

      if (!r.valid) begin
        nxt = ST_FAULT;
      end else begin
        t = sext11(r.temp);
        if (!crit_latch && t >= cfg_crit_on) crit_latch = 1'b1;
        if (crit_latch && t < cfg_crit_off) crit_latch = 1'b0;
        if (!hum_latch && r.hum >= cfg_hum_on) hum_latch = 1'b1;
        if (hum_latch && r.hum < cfg_hum_off) hum_latch = 1'b0;
        risk = (t >= cfg_cool_on);
        if (crit_latch || (risk && door_flag) || (risk && hum_latch)) begin
          nxt = ST_CRITICAL;
        end else if (door_flag) begin
          nxt = ST_DOOR;
        end else begin
          // cooling latch moves only when the decision gets this far
          if (!cool_latch && t >= cfg_cool_on) cool_latch = 1'b1;
          if (cool_latch && t <= cfg_cool_off) cool_latch = 1'b0;
          nxt = cool_latch ? ST_COOLING : ST_STEADY;
        end
      end

      urgent = (nxt == ST_CRITICAL) || (nxt == ST_FAULT);
      dt = r.now - entry_ms;
      if (nxt != room_state && (urgent || dt >= MinDwellMs)) begin
        room_state = nxt;
        entry_ms = r.now;
        changed = 1'b1;
      end
    end

    case (room_state)
      ST_CRITICAL: period = PeriodCrit;
      ST_DOOR:     period = PeriodDoor;
      ST_FAULT:    period = PeriodFault;
      default:     period = 0;
    endcase
    if (period == 0) begin
      blink_phase = 1'b0;
    end else begin
      dt = r.now - blink_start;
      if (dt >= period) begin
        blink_start = r.now;
        blink_phase = ~blink_phase;
      end
    end

    case (room_state)
      ST_FAULT: begin
        o.red = blink_phase;
        o.blue = blink_phase;
        tone = blink_phase ? TONE_1000 : TONE_OFF;
      end
      ST_CRITICAL: begin
        o.relay = 1'b1;
        o.red = blink_phase;
        tone = blink_phase ? TONE_2000 : TONE_OFF;
      end
      ST_DOOR: begin
        o.red = 1'b1;
        o.green = 1'b1;
        tone = blink_phase ? TONE_1500 : TONE_OFF;
      end
      ST_COOLING: begin
        o.relay = 1'b1;
        o.blue = 1'b1;
      end
      default: begin
        o.green = 1'b1;
      end
    endcase
    o.state = room_state;
    o.tone = tone;
    o.buzzer = (tone != TONE_OFF);
    o.door = door_flag;
    o.changed = changed;
    return o;
  endfunction

  function automatic room_req_t mk_req(input logic tick, input logic [31:0] now,
                                       input logic valid, input int temp, input int hum,
                                       input int light);
    room_req_t r;
    r.is_tick = tick;
    r.now = now;
    r.valid = valid;
    r.temp = temp[10:0];
    r.hum = hum[9:0];
    r.light = light[11:0];
    return r;
  endfunction

  // Random request; values cluster around the live thresholds
  function automatic room_req_t gen_req();
    room_req_t r;
    int roll;
    int tv;
    int hv;
    roll = $urandom_range(0, 99);
    if (roll < 70) stamp_ms += $urandom_range(0, 1200);
    else if (roll < 88) stamp_ms += $urandom_range(1200, 6000);
    else if (roll >= 96) stamp_ms = $urandom();
    r.now = stamp_ms;
    r.is_tick = ($urandom_range(0, 6) == 0);
    r.valid = ($urandom_range(0, 11) != 0);

    if ($urandom_range(0, 5) == 0) light_mode = $urandom_range(0, 2);
    case (light_mode)
      0:       r.light = $urandom_range(0, cfg_light_open);
      1:       r.light = $urandom_range(cfg_light_shut, 4095);
      default: r.light = $urandom_range(0, 4095);
    endcase

    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      case ($urandom_range(0, 3))
        0:       tv = cfg_crit_on;
        1:       tv = cfg_crit_off;
        2:       tv = cfg_cool_on;
        default: tv = cfg_cool_off;
      endcase
      tv = tv + int'($urandom_range(0, 6)) - 3;
    end else if (roll < 9) begin
      tv = int'($urandom_range(0, 1200)) - 400;
    end else begin
      tv = int'($urandom_range(0, 2047));
    end
    r.temp = tv[10:0];

    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      hv = ($urandom_range(0, 1) == 0) ? int'(cfg_hum_on) : int'(cfg_hum_off);
      hv = hv + int'($urandom_range(0, 6)) - 3;
    end else if (roll < 9) begin
      hv = int'($urandom_range(0, 1000));
    end else begin
      hv = int'($urandom_range(0, 1023));
    end
    r.hum = hv[9:0];
    return r;
  endfunction

  task automatic queue_random(input int n);
    repeat (n) sample_q.push_back(gen_req());
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || outcome_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input crs_reg_e idx, input int val);
    logic [31:0] w;
    case (idx)
      REG_CRIT_ON, REG_CRIT_OFF, REG_COOL_ON, REG_COOL_OFF: w = val & 32'h7FF;
      REG_HUM_ON, REG_HUM_OFF:                                w = val & 32'h3FF;
      default:                                                w = val & 32'hFFF;
    endcase
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= w;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CRIT_ON:    cfg_crit_on = sext11(w[10:0]);
      REG_CRIT_OFF:   cfg_crit_off = sext11(w[10:0]);
      REG_COOL_ON:    cfg_cool_on = sext11(w[10:0]);
      REG_COOL_OFF:   cfg_cool_off = sext11(w[10:0]);
      REG_HUM_ON:     cfg_hum_on = w[9:0];
      REG_HUM_OFF:    cfg_hum_off = w[9:0];
      REG_LIGHT_OPEN: cfg_light_open = w[11:0];
      default:        cfg_light_shut = w[11:0];
    endcase
  endtask

  task automatic cfg_write_all(input int crit_on, input int crit_off, input int cool_on,
                               input int cool_off, input int hum_on, input int hum_off,
                               input int light_open, input int light_shut);
    cfg_write(REG_CRIT_ON, crit_on);
    cfg_write(REG_CRIT_OFF, crit_off);
    cfg_write(REG_COOL_ON, cool_on);
    cfg_write(REG_COOL_OFF, cool_off);
    cfg_write(REG_HUM_ON, hum_on);
    cfg_write(REG_HUM_OFF, hum_off);
    cfg_write(REG_LIGHT_OPEN, light_open);
    cfg_write(REG_LIGHT_SHUT, light_shut);
  endtask

  task automatic log_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) log_mismatch($sformatf("%s got %0d expected %0d", what, got, want));
  endtask

  // Sender: bursts of random length, random gaps between them
  int burst_left = 8;
  int gap_left = 0;
  int seen_taken = 0;
  always @(negedge clk_i) begin
    if (taken_cnt != seen_taken) begin
      seen_taken = taken_cnt;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
    if (gap_left > 0) begin
      gap_left--;
      s_axis_tvalid <= 1'b0;
    end else if (rst_ni && sample_q.size() != 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= pack_req(sample_q[0]);
      s_axis_tuser <= sample_q[0].is_tick;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver: stall pattern keyed on its own cycle count
  int rx_cyc = 0;
  always @(negedge clk_i) begin
    rx_cyc++;
    case (rx_cyc[8:6])
      0, 1:    m_axis_tready <= 1'b1;
      2, 3:    m_axis_tready <= $urandom_range(0, 1);
      4:       m_axis_tready <= (rx_cyc % 5 == 0);
      5:       m_axis_tready <= (rx_cyc[3:0] >= 4'd10);
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    room_req_t req;
    room_out_t got;
    room_out_t want;
    logic      busy;
    busy = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        req = sample_q.pop_front();
        outcome_q.push_back(supervise(req));
        taken_cnt++;
        busy = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        busy = 1'b1;
        got.state   = m_axis_tdata[2:0];
        got.relay   = m_axis_tdata[3];
        got.red     = m_axis_tdata[4];
        got.green   = m_axis_tdata[5];
        got.blue    = m_axis_tdata[6];
        got.buzzer  = m_axis_tdata[7];
        got.tone    = m_axis_tdata[9:8];
        got.door    = m_axis_tdata[10];
        got.changed = m_axis_tdata[11];
        if (outcome_q.size() == 0) begin
          log_mismatch($sformatf("unexpected result tdata=%h", m_axis_tdata));
        end else begin
          want = outcome_q.pop_front();
          check_field("node_state", got.state, want.state);
          check_field("relay_on", got.relay, want.relay);
          check_field("led_red", got.red, want.red);
          check_field("led_green", got.green, want.green);
          check_field("led_blue", got.blue, want.blue);
          check_field("buzzer_on", got.buzzer, want.buzzer);
          check_field("tone_select", got.tone, want.tone);
          check_field("door_open", got.door, want.door);
          check_field("state_changed", got.changed, want.changed);
        end
      end
      if (psel && penable && pwrite && pready) busy = 1'b1;
    end
    quiet_cycles <= busy ? 0 : quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: defaults, fault, blink, extremes, door hold, combined risk, dwell, wrap
    sample_q.push_back(mk_req(1'b0, 32'd100, 1'b1, 20, 500, 3000));
    sample_q.push_back(mk_req(1'b1, 32'd200, 1'b0, 0, 0, 0));
    sample_q.push_back(mk_req(1'b0, 32'd300, 1'b0, 20, 500, 3000));
    sample_q.push_back(mk_req(1'b1, 32'd900, 1'b1, 0, 0, 4095));
    sample_q.push_back(mk_req(1'b1, 32'd1500, 1'b0, -1, 1023, 0));
    sample_q.push_back(mk_req(1'b0, 32'd5000, 1'b1, -400, 0, 4095));
    sample_q.push_back(mk_req(1'b0, 32'd5100, 1'b1, 800, 1000, 0));
    sample_q.push_back(mk_req(1'b1, 32'd5400, 1'b1, 0, 0, 0));
    sample_q.push_back(mk_req(1'b1, 32'd5700, 1'b1, 0, 0, 0));
    sample_q.push_back(mk_req(1'b0, 32'd8200, 1'b1, 75, 500, 0));
    sample_q.push_back(mk_req(1'b0, 32'd8300, 1'b1, 65, 500, 1000));
    sample_q.push_back(mk_req(1'b0, 32'd8400, 1'b1, 30, 500, 2000));
    sample_q.push_back(mk_req(1'b0, 32'd9200, 1'b1, 30, 500, 2000));
    sample_q.push_back(mk_req(1'b1, 32'd9600, 1'b1, 0, 0, 0));
    sample_q.push_back(mk_req(1'b1, 32'd10000, 1'b1, 0, 0, 0));
    sample_q.push_back(mk_req(1'b0, 32'd13300, 1'b1, 30, 500, 2500));
    sample_q.push_back(mk_req(1'b0, 32'd13400, 1'b1, 65, 760, 3000));
    sample_q.push_back(mk_req(1'b0, 32'd17500, 1'b1, 65, 690, 3000));
    sample_q.push_back(mk_req(1'b0, 32'd22000, 1'b1, 50, 690, 3000));
    sample_q.push_back(mk_req(1'b0, 32'd26100, 1'b1, 40, 690, 3000));
    sample_q.push_back(mk_req(1'b0, 32'hFFFF_FF00, 1'b1, 1023, 600, 1500));
    sample_q.push_back(mk_req(1'b1, 32'h0000_0100, 1'b1, 0, 0, 0));
    sample_q.push_back(mk_req(1'b0, 32'h7FFF_FFFF, 1'b1, -1024, 1023, 4095));
    stamp_ms = 32'h8000_0000;

    // Default thresholds, with one full pause in the middle
    queue_random(60);
    wait_drained();
    queue_random(60);
    wait_drained();

    // Extremes one way, then the other
    cfg_write_all(800, -400, -400, 800, 0, 1000, 4095, 0);
    queue_random(80);
    wait_drained();
    cfg_write_all(-400, 800, 800, -400, 1000, 0, 0, 4095);
    queue_random(80);
    wait_drained();

    // Raw register values across the full widths
    repeat (2) begin
      cfg_write_all($urandom_range(0, 2047), $urandom_range(0, 2047),
                    $urandom_range(0, 2047), $urandom_range(0, 2047),
                    $urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 4095), $urandom_range(0, 4095));
      queue_random(70);
      wait_drained();
    end

    cfg_write_all(80, 70, 60, 40, 750, 700, 1500, 2500);
    queue_random(60);
    wait_drained();

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* cold_room_supervisor.f */
hw/rtl/crs_pkg.sv
hw/rtl/crs_front.sv
hw/rtl/crs_fifo.sv
hw/rtl/crs_back.sv
hw/rtl/cold_room_supervisor.sv
tb/sv/testbench.sv
